### rtl/edf_rm_rr_task_picker_defines.svh
// Assertion helpers used by the task picker controller.
`ifndef EDF_RM_RR_TASK_PICKER_DEFINES_SVH
`define EDF_RM_RR_TASK_PICKER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define ERRTP_ASSERT_IMM(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("errtp: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define ERRTP_ASSERT_NXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("errtp: next-cycle check failed");

`endif

### rtl/errtp_pkg.sv
package errtp_pkg;

   localparam int CMD_W  = 1;
   localparam int SLOT_W = 6;
   localparam int ID_W   = 16;
   localparam int ST_W   = 3;
   localparam int POL_W  = 2;
   localparam int DL_W   = 16;
   localparam int ARR_W  = 32;
   localparam int RATE_W = 8;
   localparam int MODE_W = 2;
   localparam int KEY_W  = 33;   // deadline + arrival, no wrap
   localparam int WGT_W  = 3;    // RM weight 1..4

   localparam logic [CMD_W-1:0]  CMD_WRITE = 1'b0;
   localparam logic [CMD_W-1:0]  CMD_PICK  = 1'b1;

   localparam logic [ST_W-1:0]   ST_RUNNABLE = 3'd3;
   localparam logic [ST_W-1:0]   ST_RUNNING  = 3'd4;

   localparam logic [POL_W-1:0]  POL_NONE = 2'd0;
   localparam logic [POL_W-1:0]  POL_EDF  = 2'd1;
   localparam logic [POL_W-1:0]  POL_RM   = 2'd2;

   localparam logic [MODE_W-1:0] MODE_RR  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_EDF = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RM  = 2'd2;

   // one table row, state kept in its own memory
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [POL_W-1:0]  policy;
      logic [DL_W-1:0]   deadline;
      logic [ARR_W-1:0]  arrival;
      logic [RATE_W-1:0] rate;
   } row_type;

   typedef struct packed {
      logic tbl_wr;      // write transfer: load the addressed slot
      logic scan_init;   // pick transfer: clear trackers, address 0
      logic scan_rd;     // read one slot, advance address
      logic pick_ld;     // load pick result, mark winner running
      logic ack_ld;      // load all-zero write ack
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_last;   // address is at the last slot
   } dp_stat_type;

   // max(1, ceil(3*(30-rate)/29)) as range thresholds
   function automatic logic [WGT_W-1:0] rm_weight(input logic [RATE_W-1:0] rate);
      logic [WGT_W-1:0] w;
      if (rate == 8'd0)
         w = 3'd4;
      else if (rate <= 8'd10)
         w = 3'd3;
      else if (rate <= 8'd20)
         w = 3'd2;
      else
         w = 3'd1;
      return w;
   endfunction

endpackage

### rtl/errtp_dp.sv
module errtp_dp #(
   parameter int TABLE_SLOTS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  errtp_pkg::ctrl_cmd_type         cmd,
   output errtp_pkg::dp_stat_type          stat,
   input  logic [errtp_pkg::SLOT_W-1:0]    req_slot,
   input  logic [errtp_pkg::ID_W-1:0]      req_task_id,
   input  logic [errtp_pkg::ST_W-1:0]      req_run_state,
   input  logic [errtp_pkg::POL_W-1:0]     req_policy,
   input  logic [errtp_pkg::DL_W-1:0]      req_rel_deadline,
   input  logic [errtp_pkg::ARR_W-1:0]     req_arrival,
   input  logic [errtp_pkg::RATE_W-1:0]    req_rate,
   output logic                            rsp_found,
   output logic [errtp_pkg::SLOT_W-1:0]    rsp_picked_slot,
   output logic [errtp_pkg::ID_W-1:0]      rsp_picked_id,
   output logic [errtp_pkg::MODE_W-1:0]    rsp_mode_used
);
   import errtp_pkg::*;

   localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int SX_W  = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

   // table storage
   row_type         row_mem [TABLE_SLOTS];
   logic [ST_W-1:0] st_mem  [TABLE_SLOTS];

   logic [TABLE_SLOTS-1:0] valid_ff, valid_in;
   logic [IDX_W-1:0]       addr_ff, addr_in;

   // read stage
   row_type          row_rd_ff;
   logic [ST_W-1:0]  st_rd_ff;
   logic             vld_rd_ff;
   logic [IDX_W-1:0] idx_rd_ff;
   logic             rd_vld_ff, rd_vld_in;

   // trackers
   logic              mode_hit_ff, mode_hit_in;
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic              rr_hit_ff, rr_hit_in;
   logic [IDX_W-1:0]  rr_idx_ff, rr_idx_in;
   logic [ID_W-1:0]   rr_id_ff, rr_id_in;
   logic              edf_hit_ff, edf_hit_in;
   logic [IDX_W-1:0]  edf_idx_ff, edf_idx_in;
   logic [ID_W-1:0]   edf_id_ff, edf_id_in;
   logic [KEY_W-1:0]  edf_key_ff, edf_key_in;
   logic              rm_hit_ff, rm_hit_in;
   logic [IDX_W-1:0]  rm_idx_ff, rm_idx_in;
   logic [ID_W-1:0]   rm_id_ff, rm_id_in;
   logic [WGT_W-1:0]  rm_w_ff, rm_w_in;

   // output payload
   logic              rsp_found_ff, rsp_found_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [ID_W-1:0]   rsp_id_ff, rsp_id_in;
   logic [MODE_W-1:0] rsp_mode_ff, rsp_mode_in;

   logic [SX_W-1:0]   slot_x;
   logic [IDX_W-1:0]  wr_addr;
   logic              wr_ok;
   row_type           wr_row;
   row_type           cur_row;
   logic [ST_W-1:0]   cur_st;
   logic              cur_runnable, cur_active;
   logic [KEY_W-1:0]  cur_key;
   logic [WGT_W-1:0]  cur_w;
   logic [MODE_W-1:0] sel_mode;
   logic              sel_hit;
   logic [IDX_W-1:0]  sel_idx;
   logic [ID_W-1:0]   sel_id;
   logic [31:0]       sel_idx32;
   logic              st_we;
   logic [IDX_W-1:0]  st_waddr;
   logic [ST_W-1:0]   st_wdata;

   assign slot_x  = SX_W'(req_slot);
   assign wr_addr = slot_x[IDX_W-1:0];
   assign wr_ok   = 32'(req_slot) < TABLE_SLOTS;
   assign wr_row  = '{id: req_task_id, policy: req_policy, deadline: req_rel_deadline,
                      arrival: req_arrival, rate: req_rate};

   assign stat.scan_last = (addr_ff == IDX_W'(TABLE_SLOTS - 1));

   // never-written slots read as all zero
   assign cur_row      = vld_rd_ff ? row_rd_ff : '0;
   assign cur_st       = vld_rd_ff ? st_rd_ff : '0;
   assign cur_runnable = (cur_st == ST_RUNNABLE);
   assign cur_active   = cur_runnable || (cur_st == ST_RUNNING);
   assign cur_key      = KEY_W'(cur_row.deadline) + KEY_W'(cur_row.arrival);
   assign cur_w        = rm_weight(cur_row.rate);

   always_comb begin
      valid_in = valid_ff;
      if (cmd.tbl_wr && wr_ok)
         valid_in[wr_addr] = 1'b1;
      addr_in = addr_ff;
      if (cmd.scan_init)
         addr_in = '0;
      else if (cmd.scan_rd && !stat.scan_last)
         addr_in = addr_ff + IDX_W'(1);
      rd_vld_in = cmd.scan_rd;
   end

   // scan trackers: mode, round robin, EDF and RM candidates in one pass
   always_comb begin
      mode_hit_in = mode_hit_ff;
      mode_in     = mode_ff;
      rr_hit_in   = rr_hit_ff;
      rr_idx_in   = rr_idx_ff;
      rr_id_in    = rr_id_ff;
      edf_hit_in  = edf_hit_ff;
      edf_idx_in  = edf_idx_ff;
      edf_id_in   = edf_id_ff;
      edf_key_in  = edf_key_ff;
      rm_hit_in   = rm_hit_ff;
      rm_idx_in   = rm_idx_ff;
      rm_id_in    = rm_id_ff;
      rm_w_in     = rm_w_ff;
      if (cmd.scan_init) begin
         mode_hit_in = 1'b0;
         mode_in     = MODE_RR;
         rr_hit_in   = 1'b0;
         edf_hit_in  = 1'b0;
         rm_hit_in   = 1'b0;
      end else if (rd_vld_ff) begin
         if (!mode_hit_ff && cur_runnable && cur_row.policy != POL_NONE) begin
            mode_hit_in = 1'b1;
            mode_in     = (cur_row.policy == POL_EDF) ? MODE_EDF : MODE_RM;
         end
         if (cur_runnable && (!rr_hit_ff || cur_row.id > rr_id_ff)) begin
            rr_hit_in = 1'b1;
            rr_idx_in = idx_rd_ff;
            rr_id_in  = cur_row.id;
         end
         if (cur_active && cur_row.policy == POL_EDF &&
             (!edf_hit_ff || cur_key < edf_key_ff ||
              (cur_key == edf_key_ff && cur_row.id < edf_id_ff))) begin
            edf_hit_in = 1'b1;
            edf_idx_in = idx_rd_ff;
            edf_id_in  = cur_row.id;
            edf_key_in = cur_key;
         end
         if (cur_active && cur_row.policy == POL_RM &&
             (!rm_hit_ff || cur_w < rm_w_ff ||
              (cur_w == rm_w_ff && cur_row.id < rm_id_ff))) begin
            rm_hit_in = 1'b1;
            rm_idx_in = idx_rd_ff;
            rm_id_in  = cur_row.id;
            rm_w_in   = cur_w;
         end
      end
   end

   // final choice by mode
   always_comb begin
      sel_mode = mode_hit_ff ? mode_ff : MODE_RR;
      case (sel_mode)
         MODE_EDF: begin
            sel_hit = edf_hit_ff;
            sel_idx = edf_idx_ff;
            sel_id  = edf_id_ff;
         end
         MODE_RM: begin
            sel_hit = rm_hit_ff;
            sel_idx = rm_idx_ff;
            sel_id  = rm_id_ff;
         end
         default: begin
            sel_hit = rr_hit_ff;
            sel_idx = rr_idx_ff;
            sel_id  = rr_id_ff;
         end
      endcase
      sel_idx32 = 32'(sel_idx);
   end

   always_comb begin
      st_we    = (cmd.tbl_wr && wr_ok) || (cmd.pick_ld && sel_hit);
      st_waddr = cmd.tbl_wr ? wr_addr : sel_idx;
      st_wdata = cmd.tbl_wr ? req_run_state : ST_RUNNING;
   end

   always_comb begin
      rsp_found_in = rsp_found_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_mode_in  = rsp_mode_ff;
      if (cmd.pick_ld) begin
         rsp_found_in = sel_hit;
         rsp_slot_in  = sel_hit ? sel_idx32[SLOT_W-1:0] : '0;
         rsp_id_in    = sel_hit ? sel_id : '0;
         rsp_mode_in  = sel_mode;
      end else if (cmd.ack_ld) begin
         rsp_found_in = 1'b0;
         rsp_slot_in  = '0;
         rsp_id_in    = '0;
         rsp_mode_in  = MODE_RR;
      end
   end

   // memories: one write, one registered read
   always_ff @(posedge clock) begin
      if (cmd.tbl_wr && wr_ok)
         row_mem[wr_addr] <= wr_row;
      if (st_we)
         st_mem[st_waddr] <= st_wdata;
      if (cmd.scan_rd) begin
         row_rd_ff <= row_mem[addr_ff];
         st_rd_ff  <= st_mem[addr_ff];
         vld_rd_ff <= valid_ff[addr_ff];
         idx_rd_ff <= addr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         addr_ff     <= '0;
         rd_vld_ff   <= 1'b0;
         mode_hit_ff <= 1'b0;
         rr_hit_ff   <= 1'b0;
         edf_hit_ff  <= 1'b0;
         rm_hit_ff   <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         addr_ff     <= addr_in;
         rd_vld_ff   <= rd_vld_in;
         mode_hit_ff <= mode_hit_in;
         rr_hit_ff   <= rr_hit_in;
         edf_hit_ff  <= edf_hit_in;
         rm_hit_ff   <= rm_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      rr_idx_ff    <= rr_idx_in;
      rr_id_ff     <= rr_id_in;
      edf_idx_ff   <= edf_idx_in;
      edf_id_ff    <= edf_id_in;
      edf_key_ff   <= edf_key_in;
      rm_idx_ff    <= rm_idx_in;
      rm_id_ff     <= rm_id_in;
      rm_w_ff      <= rm_w_in;
      rsp_found_ff <= rsp_found_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_mode_ff  <= rsp_mode_in;
   end

   assign rsp_found       = rsp_found_ff;
   assign rsp_picked_slot = rsp_slot_ff;
   assign rsp_picked_id   = rsp_id_ff;
   assign rsp_mode_used   = rsp_mode_ff;

endmodule

### rtl/errtp_ctrl.sv
`include "edf_rm_rr_task_picker_defines.svh"

module errtp_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [errtp_pkg::CMD_W-1:0]    req_cmd,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output errtp_pkg::ctrl_cmd_type        cmd,
   input  errtp_pkg::dp_stat_type         stat
);
   import errtp_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_SCAN  = 4'b0010,
      S_FLUSH = 4'b0100,
      S_RESP  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      is_pick_ff, is_pick_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      req_xfer;

   assign req_ready = (state_ff == S_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      is_pick_in   = is_pick_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               is_pick_in = (req_cmd == CMD_PICK);
               if (req_cmd == CMD_PICK) begin
                  cmd.scan_init = 1'b1;
                  state_in      = S_SCAN;
               end else begin
                  cmd.tbl_wr = 1'b1;
                  state_in   = S_RESP;
               end
            end
         end
         S_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (stat.scan_last)
               state_in = S_FLUSH;
         end
         S_FLUSH: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (out_free) begin
               cmd.pick_ld  = is_pick_ff;
               cmd.ack_ld   = !is_pick_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         is_pick_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         is_pick_ff   <= is_pick_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `ERRTP_ASSERT_NXT(a_pick_starts_scan, req_xfer && (req_cmd == CMD_PICK), state_ff == S_SCAN)
   `ERRTP_ASSERT_NXT(a_scan_runs_to_end, (state_ff == S_SCAN) && !stat.scan_last, state_ff == S_SCAN)
   `ERRTP_ASSERT_IMM(a_load_needs_room, cmd.pick_ld || cmd.ack_ld, !rsp_valid_ff || rsp_ready)

endmodule

### rtl/edf_rm_rr_task_picker.sv
// Channel  | Ports                                          | Direction
// ---------+------------------------------------------------+----------
// request  | req_valid/req_ready, req_cmd .. req_rate       | in
// response | rsp_valid/rsp_ready, rsp_found .. rsp_mode_used| out
//
// Write transfer: slot is loaded in the accept cycle; S_RESP then loads the ack once
// the output register is free, raising rsp_valid. Pick transfer: the table read
// scans one slot per cycle in S_SCAN, one compare each, then S_FLUSH and S_RESP follow.
// Reset clears the table valid bits at once; no clearing pass is needed.
// A stalled response holds in the output register; the next request is
// taken as soon as the response is loaded, even if it is not yet taken.
module edf_rm_rr_task_picker #(
   parameter int TABLE_SLOTS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [errtp_pkg::CMD_W-1:0]     req_cmd,
   input  logic [errtp_pkg::SLOT_W-1:0]    req_slot,
   input  logic [errtp_pkg::ID_W-1:0]      req_task_id,
   input  logic [errtp_pkg::ST_W-1:0]      req_run_state,
   input  logic [errtp_pkg::POL_W-1:0]     req_policy,
   input  logic [errtp_pkg::DL_W-1:0]      req_rel_deadline,
   input  logic [errtp_pkg::ARR_W-1:0]     req_arrival,
   input  logic [errtp_pkg::RATE_W-1:0]    req_rate,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_found,
   output logic [errtp_pkg::SLOT_W-1:0]    rsp_picked_slot,
   output logic [errtp_pkg::ID_W-1:0]      rsp_picked_id,
   output logic [errtp_pkg::MODE_W-1:0]    rsp_mode_used
);
   import errtp_pkg::*;

   ctrl_cmd_type cmd;   // controller -> datapath
   dp_stat_type  stat;  // datapath -> controller

   // sequencer: accept, scan and flush the read stage on a pick, load the response
   errtp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // table memories, scan trackers for all three modes, response register
   errtp_dp #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_slot         (req_slot),
      .req_task_id      (req_task_id),
      .req_run_state    (req_run_state),
      .req_policy       (req_policy),
      .req_rel_deadline (req_rel_deadline),
      .req_arrival      (req_arrival),
      .req_rate         (req_rate),
      .rsp_found        (rsp_found),
      .rsp_picked_slot  (rsp_picked_slot),
      .rsp_picked_id    (rsp_picked_id),
      .rsp_mode_used    (rsp_mode_used)
   );

endmodule

### tb/pick_checker.sv
module pick_checker #(
   parameter int TABLE_SLOTS = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [errtp_pkg::CMD_W-1:0]    req_cmd,
   input  logic [errtp_pkg::SLOT_W-1:0]   req_slot,
   input  logic [errtp_pkg::ID_W-1:0]     req_task_id,
   input  logic [errtp_pkg::ST_W-1:0]     req_run_state,
   input  logic [errtp_pkg::POL_W-1:0]    req_policy,
   input  logic [errtp_pkg::DL_W-1:0]     req_rel_deadline,
   input  logic [errtp_pkg::ARR_W-1:0]    req_arrival,
   input  logic [errtp_pkg::RATE_W-1:0]   req_rate,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic                           rsp_found,
   input  logic [errtp_pkg::SLOT_W-1:0]   rsp_picked_slot,
   input  logic [errtp_pkg::ID_W-1:0]     rsp_picked_id,
   input  logic [errtp_pkg::MODE_W-1:0]   rsp_mode_used,
   output int unsigned                    mismatches,
   output int unsigned                    awaiting
);
   timeunit 1ns;
   timeprecision 1ps;
   import errtp_pkg::*;

   typedef struct {
      logic [ST_W-1:0]   run_state;
      logic [POL_W-1:0]  policy;
      logic [ID_W-1:0]   id;
      logic [DL_W-1:0]   deadline;
      logic [ARR_W-1:0]  arrival;
      logic [RATE_W-1:0] rate;
   } task_entry_type;

   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] slot;
      logic [ID_W-1:0]   id;
      logic [MODE_W-1:0] mode;
   } pick_result_type;

   task_entry_type  task_table [TABLE_SLOTS];
   pick_result_type expected_picks [$];
   int unsigned     error_total = 0;

   // RM weight: max(1, ceil(3*(30-rate)/29))
   function automatic int unsigned rate_weight(input logic [RATE_W-1:0] rate);
      if (rate >= 30)
         return 1;
      return (3 * (30 - int'(rate)) + 28) / 29;
   endfunction

   function automatic bit is_active(input int idx);
      return task_table[idx].run_state == ST_RUNNABLE ||
             task_table[idx].run_state == ST_RUNNING;
   endfunction

   // Next pick from the table; the winner is marked running.
   function automatic pick_result_type predict_pick();
      pick_result_type   res;
      logic [MODE_W-1:0] mode;
      bit                mode_set;
      int                best;
      logic [KEY_W-1:0]  key;
      logic [KEY_W-1:0]  best_key;
      int unsigned       wgt;
      int unsigned       best_wgt;
      res      = '0;
      mode     = MODE_RR;
      mode_set = 1'b0;
      best     = -1;
      best_key = '0;
      best_wgt = 0;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         if (!mode_set && task_table[i].run_state == ST_RUNNABLE &&
             task_table[i].policy != POL_NONE) begin
            mode     = (task_table[i].policy == POL_EDF) ? MODE_EDF : MODE_RM;
            mode_set = 1'b1;
         end
      end
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         if (mode == MODE_RR) begin
            if (task_table[i].run_state == ST_RUNNABLE &&
                (best < 0 || task_table[i].id > task_table[best].id))
               best = i;
         end else if (mode == MODE_EDF) begin
            if (is_active(i) && task_table[i].policy == POL_EDF) begin
               key = KEY_W'(task_table[i].arrival) + KEY_W'(task_table[i].deadline);
               if (best < 0 || key < best_key ||
                   (key == best_key && task_table[i].id < task_table[best].id)) begin
                  best     = i;
                  best_key = key;
               end
            end
         end else begin
            if (is_active(i) && task_table[i].policy == POL_RM) begin
               wgt = rate_weight(task_table[i].rate);
               if (best < 0 || wgt < best_wgt ||
                   (wgt == best_wgt && task_table[i].id < task_table[best].id)) begin
                  best     = i;
                  best_wgt = wgt;
               end
            end
         end
      end
      res.mode = mode;
      if (best >= 0) begin
         task_table[best].run_state = ST_RUNNING;
         res.found = 1'b1;
         res.slot  = SLOT_W'(best);
         res.id    = task_table[best].id;
      end
      return res;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         error_total++;
      end
   endtask

   always @(posedge clock) begin
      pick_result_type want;
      if (reset) begin
         for (int i = 0; i < TABLE_SLOTS; i++)
            task_table[i] = '{default: '0};
         expected_picks.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_picks.size() == 0) begin
               $display({"%0t ns: response transfer with nothing outstanding, ",
                         "expected none, got %0b/%0h/%0h/%0h"},
                        $time, rsp_found, rsp_picked_slot, rsp_picked_id, rsp_mode_used);
               error_total++;
            end else begin
               want = expected_picks.pop_front();
               check_field("found", 32'(want.found), 32'(rsp_found));
               check_field("picked_slot", 32'(want.slot), 32'(rsp_picked_slot));
               check_field("picked_id", 32'(want.id), 32'(rsp_picked_id));
               check_field("mode_used", 32'(want.mode), 32'(rsp_mode_used));
            end
         end
         if (req_valid && req_ready) begin
            if (req_cmd == CMD_WRITE) begin
               if (req_slot < TABLE_SLOTS) begin
                  task_table[req_slot].run_state = req_run_state;
                  task_table[req_slot].policy    = req_policy;
                  task_table[req_slot].id        = req_task_id;
                  task_table[req_slot].deadline  = req_rel_deadline;
                  task_table[req_slot].arrival   = req_arrival;
                  task_table[req_slot].rate      = req_rate;
               end
               expected_picks.push_back('0);
            end else begin
               expected_picks.push_back(predict_pick());
            end
         end
      end
      mismatches <= error_total;
      awaiting   <= unsigned'(expected_picks.size());
   end

endmodule

### tb/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import errtp_pkg::*;

   localparam int SLOTS            = 64;
   localparam int ITEMS_PER_PHASE  = 300;

   // run_state codes the package does not name
   localparam logic [ST_W-1:0]  ST_UNUSED   = 3'd0;
   localparam logic [ST_W-1:0]  ST_SLEEPING = 3'd2;
   localparam logic [ST_W-1:0]  ST_ZOMBIE   = 3'd5;
   localparam logic [ST_W-1:0]  ST_SPARE_A  = 3'd6;
   localparam logic [ST_W-1:0]  ST_SPARE_B  = 3'd7;
   // policy code 3: selects RM mode but is never an RM candidate
   localparam logic [POL_W-1:0] POL_SPARE   = 2'd3;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [CMD_W-1:0]    req_cmd = CMD_WRITE;
   logic [SLOT_W-1:0]   req_slot = '0;
   logic [ID_W-1:0]     req_task_id = '0;
   logic [ST_W-1:0]     req_run_state = '0;
   logic [POL_W-1:0]    req_policy = '0;
   logic [DL_W-1:0]     req_rel_deadline = '0;
   logic [ARR_W-1:0]    req_arrival = '0;
   logic [RATE_W-1:0]   req_rate = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_found;
   logic [SLOT_W-1:0]   rsp_picked_slot;
   logic [ID_W-1:0]     rsp_picked_id;
   logic [MODE_W-1:0]   rsp_mode_used;

   int unsigned         mismatches;
   int unsigned         awaiting;
   int unsigned         items_sent = 0;
   // percent of cycles each side sits idle; changed only at a rising edge
   int unsigned         send_idle_pct = 17;
   int unsigned         recv_idle_pct = 53;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   edf_rm_rr_task_picker #(.TABLE_SLOTS(SLOTS)) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_slot         (req_slot),
      .req_task_id      (req_task_id),
      .req_run_state    (req_run_state),
      .req_policy       (req_policy),
      .req_rel_deadline (req_rel_deadline),
      .req_arrival      (req_arrival),
      .req_rate         (req_rate),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found        (rsp_found),
      .rsp_picked_slot  (rsp_picked_slot),
      .rsp_picked_id    (rsp_picked_id),
      .rsp_mode_used    (rsp_mode_used)
   );

   // Watches both channels, predicts every pick, compares each response.
   pick_checker #(.TABLE_SLOTS(SLOTS)) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_slot         (req_slot),
      .req_task_id      (req_task_id),
      .req_run_state    (req_run_state),
      .req_policy       (req_policy),
      .req_rel_deadline (req_rel_deadline),
      .req_arrival      (req_arrival),
      .req_rate         (req_rate),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found        (rsp_found),
      .rsp_picked_slot  (rsp_picked_slot),
      .rsp_picked_id    (rsp_picked_id),
      .rsp_mode_used    (rsp_mode_used),
      .mismatches       (mismatches),
      .awaiting         (awaiting)
   );

   // Response side backpressure, redrawn every falling edge.
   always @(negedge clock)
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

   // One request transfer. Entered and left just after a rising edge.
   // Valid drops only during an idle gap, so back-to-back items keep it high
   // and it gets one assignment per falling edge.
   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                            input logic [ID_W-1:0] id, input logic [ST_W-1:0] st,
                            input logic [POL_W-1:0] pol, input logic [DL_W-1:0] dl,
                            input logic [ARR_W-1:0] arr, input logic [RATE_W-1:0] rate);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_cmd          <= cmd;
      req_slot         <= slot;
      req_task_id      <= id;
      req_run_state    <= st;
      req_policy       <= pol;
      req_rel_deadline <= dl;
      req_arrival      <= arr;
      req_rate         <= rate;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // Pick with junk in the unused payload fields.
   task automatic send_pick();
      send_item(CMD_PICK, SLOT_W'($urandom), ID_W'($urandom), ST_W'($urandom),
                POL_W'($urandom), DL_W'($urandom), $urandom, RATE_W'($urandom));
   endtask

   // Random slot write. slot_sel/pol_sel < 0 means draw at random;
   // retire forces a state that is neither runnable nor running.
   task automatic send_random_write(input int slot_sel, input int pol_sel, input bit retire);
      logic [SLOT_W-1:0] slot;
      logic [ST_W-1:0]   st;
      logic [POL_W-1:0]  pol;
      logic [ID_W-1:0]   id;
      logic [DL_W-1:0]   dl;
      logic [ARR_W-1:0]  arr;
      logic [RATE_W-1:0] rate;
      int unsigned       r;
      bit                dense;
      // most writes hit a small window so slots compete and get rewritten
      dense = ($urandom_range(0, 99) < 85);
      if (slot_sel >= 0)
         slot = SLOT_W'(slot_sel);
      else if (dense)
         slot = SLOT_W'($urandom_range(0, 7));
      else
         slot = SLOT_W'($urandom_range(0, SLOTS - 1));
      r = $urandom_range(0, 99);
      if (retire || slot_sel >= 0) begin
         do st = ST_W'($urandom_range(0, 7)); while (st == ST_RUNNABLE || st == ST_RUNNING);
      end else if (dense && r < 55) begin
         st = ST_RUNNABLE;
      end else if (dense && r < 70) begin
         st = ST_RUNNING;
      end else begin
         st = ST_W'($urandom_range(0, 7));
      end
      r = $urandom_range(0, 99);
      if (pol_sel >= 0)
         pol = POL_W'(pol_sel);
      else if (r < 28)
         pol = POL_NONE;
      else if (r < 58)
         pol = POL_EDF;
      else if (r < 90)
         pol = POL_RM;
      else
         pol = POL_SPARE;
      // small ids, deadlines and arrivals make ties common
      id = ($urandom_range(0, 99) < 40) ? ID_W'($urandom_range(0, 7)) : ID_W'($urandom);
      dl = ($urandom_range(0, 99) < 30) ? DL_W'($urandom_range(0, 3)) : DL_W'($urandom);
      r = $urandom_range(0, 99);
      if (r < 30)
         arr = $urandom_range(0, 3);
      else if (r < 40)
         arr = 32'hFFFF_FFFF - $urandom_range(0, 3);   // EDF key can carry into bit 32
      else
         arr = $urandom;
      rate = ($urandom_range(0, 99) < 50) ? RATE_W'($urandom_range(0, 31))
                                          : RATE_W'($urandom_range(0, 255));
      send_item(CMD_WRITE, slot, id, st, pol, dl, arr, rate);
   endtask

   // Up to six writes then one to three picks. Some bursts share one policy to stack
   // up competition, some retire tasks so round robin gets its turn.
   task automatic run_burst();
      int unsigned kind;
      int unsigned n_wr;
      int unsigned n_pk;
      int          pol_sel;
      kind    = $urandom_range(0, 99);
      n_wr    = $urandom_range(0, 6);
      n_pk    = $urandom_range(1, 3);
      pol_sel = (kind < 30) ? int'($urandom_range(0, 2)) : -1;
      repeat (n_wr) send_random_write(-1, pol_sel, kind >= 85);
      repeat (n_pk) send_pick();
   endtask

   // Hold off the sender until every expected response is back.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaiting != 0) @(negedge clock);
      @(posedge clock);
   endtask

   initial begin
      int unsigned phase_start;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed ----
      // empty table: round robin, nothing found
      send_pick();
      // round robin extremes of id and slot
      send_item(CMD_WRITE, 6'd0, 16'hFFFF, ST_RUNNABLE, POL_NONE, 16'h0, 32'h0, 8'h0);
      send_item(CMD_WRITE, 6'd63, 16'h0, ST_RUNNABLE, POL_NONE, 16'hFFFF,
                32'hFFFF_FFFF, 8'hFF);
      send_pick();
      send_pick();
      send_pick();   // both now running: nothing left for round robin
      // policy code 3 forces RM mode with no RM candidate
      send_item(CMD_WRITE, 6'd5, 16'h1234, ST_RUNNABLE, POL_SPARE, 16'h10, 32'h20, 8'd1);
      send_pick();
      // RM weights: rate 0 -> 4, 255 and 21 -> 1 (tie, lower id), 20 -> 2, 10 -> 3
      send_item(CMD_WRITE, 6'd10, 16'd7, ST_RUNNING, POL_RM, 16'h0, 32'h0, 8'd0);
      send_item(CMD_WRITE, 6'd11, 16'd9, ST_RUNNABLE, POL_RM, 16'h0, 32'h0, 8'd255);
      send_item(CMD_WRITE, 6'd12, 16'd3, ST_RUNNABLE, POL_RM, 16'h0, 32'h0, 8'd21);
      send_pick();
      send_item(CMD_WRITE, 6'd13, 16'd2, ST_RUNNABLE, POL_RM, 16'h0, 32'h0, 8'd20);
      send_item(CMD_WRITE, 6'd14, 16'd1, ST_RUNNABLE, POL_RM, 16'h0, 32'h0, 8'd10);
      send_pick();   // running RM task stays a candidate
      // spare state codes count as neither runnable nor running
      send_item(CMD_WRITE, 6'd5, 16'h1234, ST_SPARE_B, POL_EDF, 16'h0, 32'h0, 8'd0);
      send_item(CMD_WRITE, 6'd7, 16'h4321, ST_SPARE_A, POL_RM, 16'h0, 32'h0, 8'd0);
      // EDF: 33-bit keys, equal key and id -> earliest slot
      send_item(CMD_WRITE, 6'd2, 16'd1, ST_RUNNABLE, POL_EDF, 16'hFFFF,
                32'hFFFF_FFFF, 8'd0);
      send_item(CMD_WRITE, 6'd3, 16'd2, ST_RUNNABLE, POL_EDF, 16'd1, 32'hFFFF_FFFF, 8'd0);
      send_item(CMD_WRITE, 6'd4, 16'd2, ST_RUNNING, POL_EDF, 16'd1, 32'hFFFF_FFFF, 8'd0);
      send_pick();
      // zombie is skipped; running EDF task with key 0 wins
      send_item(CMD_WRITE, 6'd1, 16'd0, ST_ZOMBIE, POL_EDF, 16'h0, 32'h0, 8'd0);
      send_item(CMD_WRITE, 6'd6, 16'hABCD, ST_RUNNING, POL_EDF, 16'h0, 32'h0, 8'd0);
      send_pick();
      // rate 30 goes to a sleeping slot, which drops out of mode choice
      send_item(CMD_WRITE, 6'd2, 16'd5, ST_SLEEPING, POL_RM, 16'h0, 32'h0, 8'd30);
      send_pick();

      // ---- random, three backpressure phases ----
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 17;
               recv_idle_pct = 53;
            end
            1: begin
               send_idle_pct = 53;
               recv_idle_pct = 17;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         phase_start = items_sent;
         // sweep the whole table to idle states so every slot is touched
         for (int s = 0; s < SLOTS; s++)
            send_random_write(s, -1, 1'b1);
         while (items_sent - phase_start < ITEMS_PER_PHASE)
            run_burst();
         drain();
      end

      // latency of a full scan plus margin for any stray response
      repeat (SLOTS + 8) @(negedge clock);
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // Watchdog, several times the slowest legal run.
   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
